### rtl/sfpp_pkg.sv
package sfpp_pkg;

    // frame layout and default limits
    localparam int MAX_PAYLOAD_DEF = 64;
    localparam int HDR_LEN         = 6;
    localparam int LEN_W           = 7;
    localparam int IDX_W           = 6;
    localparam int CFG_IDX_W       = 1;

    // crc-16/ccitt-false
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    // configuration register reset values
    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC_FIRST  = 1'b0,
        REG_SYNC_SECOND = 1'b1
    } cfg_reg_t;

    // parser states
    typedef enum logic [2:0] {
        ST_HUNT1 = 3'd0,
        ST_HUNT2 = 3'd1,
        ST_HDR   = 3'd2,
        ST_PAY   = 3'd3,
        ST_CRCL  = 3'd4,
        ST_CRCH  = 3'd5,
        ST_EMIT  = 3'd6
    } phase_t;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic hdr_start;
        logic hdr_write;
        logic pay_write;
        logic crcl_write;
        logic emit_start;
        logic emit_active;
        logic clear;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_sync1;
        logic is_sync2;
        logic hdr_last;
        logic len_over;
        logic len_zero;
        logic pay_last;
        logic crc_ok;
        logic emit_done;
        logic rd_busy;
    } sts_t;

    // one byte through the crc, msb first
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### rtl/sfpp_ram.sv
module sfpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/sfpp_ctrl.sv
module sfpp_ctrl
    import sfpp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  sts_t sts,
    output cmd_t cmd
);

    phase_t state_reg;
    phase_t state_next;
    logic   accept;

    assign accept = in_valid && (state_reg != ST_EMIT);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_HUNT1:
            begin
                if (accept && sts.is_sync1)
                    state_next = ST_HUNT2;
            end
            ST_HUNT2:
            begin
                if (accept)
                begin
                    if (sts.is_sync2)
                        state_next = ST_HDR;
                    else if (!sts.is_sync1)
                        state_next = ST_HUNT1;
                end
            end
            ST_HDR:
            begin
                if (accept && sts.hdr_last)
                begin
                    if (sts.len_over)
                        state_next = ST_HUNT1;
                    else if (sts.len_zero)
                        state_next = ST_CRCL;
                    else
                        state_next = ST_PAY;
                end
            end
            ST_PAY:
            begin
                if (accept && sts.pay_last)
                    state_next = ST_CRCL;
            end
            ST_CRCL:
            begin
                if (accept)
                    state_next = ST_CRCH;
            end
            ST_CRCH:
            begin
                if (accept)
                    state_next = sts.crc_ok ? ST_EMIT : ST_HUNT1;
            end
            ST_EMIT:
            begin
                if (sts.emit_done)
                    state_next = ST_HUNT1;
            end
            default:
            begin
                state_next = ST_HUNT1;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        cmd.in_ready = (state_reg != ST_EMIT);
        case (state_reg)
            ST_HUNT1:
            begin
            end
            ST_HUNT2:
            begin
                cmd.hdr_start = accept && sts.is_sync2;
            end
            ST_HDR:
            begin
                cmd.hdr_write = accept;
                cmd.clear     = accept && sts.hdr_last && sts.len_over;
            end
            ST_PAY:
            begin
                cmd.pay_write = accept;
            end
            ST_CRCL:
            begin
                cmd.crcl_write = accept;
            end
            ST_CRCH:
            begin
                cmd.emit_start = accept && sts.crc_ok;
                cmd.clear      = accept && !sts.crc_ok;
            end
            ST_EMIT:
            begin
                cmd.emit_active = 1'b1;
                cmd.clear       = sts.emit_done;
            end
            default:
            begin
                cmd.clear = 1'b1;
            end
        endcase
    end

endmodule

### rtl/sfpp_datapath.sv
module sfpp_datapath
    import sfpp_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic [7:0]           rx_byte,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [7:0]           version,
    output logic [7:0]           frame_type,
    output logic [7:0]           flag_bits,
    output logic [7:0]           sequence_res,
    output logic [LEN_W-1:0]     payload_length,
    output logic                 has_payload,
    output logic [IDX_W-1:0]     byte_index,
    output logic [7:0]           data_byte,
    output logic                 last
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0]       sync_first_reg;
    logic [7:0]       sync_second_reg;
    logic [7:0]       version_reg;
    logic [7:0]       frame_type_reg;
    logic [7:0]       flag_bits_reg;
    logic [7:0]       sequence_reg;
    logic [7:0]       len_lo_reg;
    logic [2:0]       hdr_cnt_reg;
    logic [LEN_W-1:0] pay_cnt_reg;
    logic [LEN_W-1:0] exp_len_reg;
    logic [7:0]       crc_low_reg;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [15:0]      frame_len;
    logic [LEN_W-1:0] pay_cnt_inc;

    // replay pipeline
    logic [LEN_W-1:0] emit_cnt_reg;
    logic [LEN_W-1:0] emit_last_cnt;
    logic             issued_all_reg;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_last_reg;
    logic             issue;
    logic             issue_last;
    logic             advance;
    logic             load_out;
    logic [7:0]       ram_q;

    // output register
    logic             out_valid_reg;
    logic [7:0]       version_out_reg;
    logic [7:0]       frame_type_out_reg;
    logic [7:0]       flag_bits_out_reg;
    logic [7:0]       sequence_out_reg;
    logic [LEN_W-1:0] length_out_reg;
    logic             has_payload_out_reg;
    logic [IDX_W-1:0] index_out_reg;
    logic [7:0]       data_out_reg;
    logic             last_out_reg;

    // status toward the controller
    assign crc_next    = crc16_feed(crc_reg, rx_byte);
    assign frame_len   = {rx_byte, len_lo_reg};
    assign pay_cnt_inc = pay_cnt_reg + LEN_W'(1);

    always_comb
    begin
        sts           = '0;
        sts.is_sync1  = (rx_byte == sync_first_reg);
        sts.is_sync2  = (rx_byte == sync_second_reg);
        sts.hdr_last  = (hdr_cnt_reg == 3'(HDR_LEN - 1));
        sts.len_over  = (frame_len > 16'(MAX_PAYLOAD));
        sts.len_zero  = (frame_len == 16'h0000);
        sts.pay_last  = (pay_cnt_inc >= exp_len_reg);
        sts.crc_ok    = ({rx_byte, crc_low_reg} == crc_reg);
        sts.emit_done = issued_all_reg && (!rd_valid_reg || load_out);
        sts.rd_busy   = rd_valid_reg;
    end

    // sync pattern registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                REG_SYNC_SECOND: sync_second_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // header fields
    always_ff @(posedge clk)
    begin
        if (cmd.hdr_write)
        begin
            case (hdr_cnt_reg)
                3'd0:    version_reg    <= rx_byte;
                3'd1:    frame_type_reg <= rx_byte;
                3'd2:    flag_bits_reg  <= rx_byte;
                3'd3:    sequence_reg   <= rx_byte;
                3'd4:    len_lo_reg     <= rx_byte;
                default:
                begin
                end
            endcase
        end
    end

    // parse counters and running crc
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg <= '0;
            pay_cnt_reg <= '0;
            exp_len_reg <= '0;
            crc_low_reg <= '0;
            crc_reg     <= CRC_INIT;
        end
        else if (cmd.clear)
        begin
            hdr_cnt_reg <= '0;
            pay_cnt_reg <= '0;
            exp_len_reg <= '0;
            crc_low_reg <= '0;
        end
        else
        begin
            if (cmd.hdr_start)
            begin
                hdr_cnt_reg <= '0;
                crc_reg     <= CRC_INIT;
            end
            if (cmd.hdr_write)
            begin
                hdr_cnt_reg <= hdr_cnt_reg + 3'd1;
                crc_reg     <= crc_next;
                if (sts.hdr_last)
                begin
                    exp_len_reg <= frame_len[LEN_W-1:0];
                    pay_cnt_reg <= '0;
                end
            end
            if (cmd.pay_write)
            begin
                pay_cnt_reg <= pay_cnt_inc;
                crc_reg     <= crc_next;
            end
            if (cmd.crcl_write)
            begin
                crc_low_reg <= rx_byte;
            end
        end
    end

    // replay read issue
    assign load_out      = rd_valid_reg && (!out_valid_reg || out_ready);
    assign advance       = !rd_valid_reg || load_out;
    assign issue         = cmd.emit_active && !issued_all_reg && advance;
    assign emit_last_cnt = (exp_len_reg == '0) ? '0 : (exp_len_reg - LEN_W'(1));
    assign issue_last    = (emit_cnt_reg == emit_last_cnt);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_cnt_reg   <= '0;
            issued_all_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.emit_start)
            begin
                emit_cnt_reg   <= '0;
                issued_all_reg <= 1'b0;
            end
            else if (issue)
            begin
                emit_cnt_reg   <= emit_cnt_reg + LEN_W'(1);
                issued_all_reg <= issue_last;
            end
            if (issue)
                rd_valid_reg <= 1'b1;
            else if (load_out)
                rd_valid_reg <= 1'b0;
        end
    end

    // read stage word tags
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_idx_reg  <= emit_cnt_reg[IDX_W-1:0];
            rd_last_reg <= issue_last;
        end
    end

    // payload store
    sfpp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_pay_ram (
        .clk     (clk),
        .wr_en   (cmd.pay_write),
        .wr_addr (pay_cnt_reg[AW-1:0]),
        .wr_data (rx_byte),
        .rd_en   (issue),
        .rd_addr (emit_cnt_reg[AW-1:0]),
        .rd_data (ram_q)
    );

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            version_out_reg     <= version_reg;
            frame_type_out_reg  <= frame_type_reg;
            flag_bits_out_reg   <= flag_bits_reg;
            sequence_out_reg    <= sequence_reg;
            length_out_reg      <= exp_len_reg;
            has_payload_out_reg <= (exp_len_reg != '0);
            index_out_reg       <= (exp_len_reg != '0) ? rd_idx_reg : '0;
            data_out_reg        <= (exp_len_reg != '0) ? ram_q : 8'h00;
            last_out_reg        <= rd_last_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign version        = version_out_reg;
    assign frame_type     = frame_type_out_reg;
    assign flag_bits      = flag_bits_out_reg;
    assign sequence_res   = sequence_out_reg;
    assign payload_length = length_out_reg;
    assign has_payload    = has_payload_out_reg;
    assign byte_index     = index_out_reg;
    assign data_byte      = data_out_reg;
    assign last           = last_out_reg;

endmodule

### rtl/sync_framed_packet_parser.sv
// channel  | direction | handshake              | words
// ---------+-----------+------------------------+----------------------------------
// in       | input     | in_valid / in_ready    | rx_byte, one stream byte
// out      | output    | out_valid / out_ready  | header fields + one payload byte
// cfg      | input     | cfg_we (no wait)       | cfg_index, cfg_data
//
// each received byte is taken while in_valid and in_ready are both high;
// the crc advances a byte per cycle over the header and payload bytes taken
// a good frame replays max(length,1) words from the payload ram at one per cycle
// while out_ready holds, each via the ram read register and the output register;
// in_ready is low in the emit state; out stalls hold the replay; the final word may
// wait while new bytes enter; rst_n is asynchronous; the payload ram is not cleared
module sync_framed_packet_parser
    import sfpp_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           rx_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           version,
    output logic [7:0]           frame_type,
    output logic [7:0]           flag_bits,
    output logic [7:0]           sequence_res,
    output logic [LEN_W-1:0]     payload_length,
    output logic                 has_payload,
    output logic [IDX_W-1:0]     byte_index,
    output logic [7:0]           data_byte,
    output logic                 last
);

    cmd_t cmd;
    sts_t sts;

    // frame state machine
    sfpp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd)
    );

    // header, crc, payload store and replay
    sfpp_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rx_byte        (rx_byte),
        .cmd            (cmd),
        .sts            (sts),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .version        (version),
        .frame_type     (frame_type),
        .flag_bits      (flag_bits),
        .sequence_res   (sequence_res),
        .payload_length (payload_length),
        .has_payload    (has_payload),
        .byte_index     (byte_index),
        .data_byte      (data_byte),
        .last           (last)
    );

    assign in_ready = cmd.in_ready;

    // an empty frame gives one word only, marked last
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_payload) |-> last)
        else $error("empty frame word not marked last");

    // payload index stays inside the frame length
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && has_payload) |-> ({1'b0, byte_index} < payload_length))
        else $error("byte_index beyond payload_length");

    // no byte enters while the replay read stage still holds a word
    a_no_accept_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !sts.rd_busy)
        else $error("byte accepted during replay");

endmodule
